>>> src/heading_pid_controller_core_assert.svh
// Assertion macros for the heading PID controller core.
// Needs nothing else; included by the core module.
`ifndef HEADING_PID_CONTROLLER_CORE_ASSERT_SVH
`define HEADING_PID_CONTROLLER_CORE_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define HPC_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("heading pid controller: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define HPC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("heading pid controller: next-cycle check failed");

`endif

>>> src/hpc_pkg.sv
// Constants, widths and the CORDIC arctangent table of the heading PID controller.
// Stands alone; used by heading_pid_controller_core.
package hpc_pkg;

    localparam int UPDATE_RATE_HZ = 16;
    localparam int CORDIC_STEPS   = 16;

    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_ITERS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);
    localparam int ATAN_IDX_W   = 5;

    localparam int IN_W     = 24;
    localparam int DX_W     = IN_W + 1;
    localparam int CORDIC_W = 28;
    localparam int ZR_W     = CORDIC_W + 1;
    localparam int HALF_PI_Q24  = 26353589;
    localparam int BEARING_SH   = 11;
    localparam int BEARING_HALF = 1 << (BEARING_SH - 1);

    localparam int E_W     = 16;
    localparam int PI_Q13  = 25736;
    localparam int DIFF_W  = E_W + 1;
    localparam int RATE_W  = $clog2(UPDATE_RATE_HZ + 1);
    localparam int D_W     = DIFF_W + RATE_W;

    localparam int INT_SH    = 10;
    localparam int EABS_W    = E_W - 1;
    localparam int MAG_W     = EABS_W + INT_SH + 1;
    localparam int HALF_RATE = UPDATE_RATE_HZ / 2;
    localparam int DIV_SH    = MAG_W;
    localparam int RECIP     = (1 << DIV_SH) / UPDATE_RATE_HZ;
    localparam int RECIP_W   = DIV_SH + 1;
    localparam int INC_W     = MAG_W + 1;
    localparam int INTEG_W   = 32;

    localparam int GAIN_W    = 16;
    localparam int MUL_A_W   = RECIP_W + 1;
    localparam int MUL_B_W   = INTEG_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int KD_TERM_W = GAIN_W + D_W + INT_SH;
    localparam int KI_TERM_W = GAIN_W + INTEG_W;
    localparam int ACC_W     = ((KD_TERM_W > KI_TERM_W) ? KD_TERM_W : KI_TERM_W) + 2;
    localparam int OUT_SH    = 23;
    localparam int OUT_HALF  = 1 << (OUT_SH - 1);
    localparam int OUT_W     = 16;
    localparam int OUT_MAX   = 32767;
    localparam int OUT_MIN   = -32768;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_KP    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KI    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KD    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED = 8'd3;

    localparam int S_DATA_W = 4 * IN_W;
    localparam int M_DATA_W = 3 * OUT_W;

    function automatic logic signed [CORDIC_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [CORDIC_W-1:0] v;
        case (idx)
            5'd0:    v = 28'sd13176795;
            5'd1:    v = 28'sd7778716;
            5'd2:    v = 28'sd4110060;
            5'd3:    v = 28'sd2086331;
            5'd4:    v = 28'sd1047214;
            5'd5:    v = 28'sd524117;
            5'd6:    v = 28'sd262123;
            5'd7:    v = 28'sd131069;
            5'd8:    v = 28'sd65536;
            5'd9:    v = 28'sd32768;
            5'd10:   v = 28'sd16384;
            5'd11:   v = 28'sd8192;
            5'd12:   v = 28'sd4096;
            5'd13:   v = 28'sd2048;
            5'd14:   v = 28'sd1024;
            5'd15:   v = 28'sd512;
            5'd16:   v = 28'sd256;
            5'd17:   v = 28'sd128;
            5'd18:   v = 28'sd64;
            5'd19:   v = 28'sd32;
            5'd20:   v = 28'sd16;
            5'd21:   v = 28'sd8;
            5'd22:   v = 28'sd4;
            5'd23:   v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> src/heading_pid_controller_core.sv
// Heading PID controller: CORDIC bearing to goal, then a PID step on that bearing.
// Depends on hpc_pkg and heading_pid_controller_core_assert.svh.
//
// Usage:
//   The s_ stream carries one request per control tick: goal and robot position.
//   The m_ stream returns one result per request: angular rate, linear rate and
//   the bearing error. The cfg channel writes the gains and the forward speed;
//   cfg_ready is always high, write only while no request is in flight.
// Timing:
//   One iterative add/shift datapath runs the CORDIC, one iteration per cycle, and
//   one shared multiplier then forms the reciprocal divide and the three gain terms.
//   After a request is accepted the sequencer steps through CORDIC, ROUND, DIVM,
//   DIVF, INTEG, MULI, MULD, ACCD and FIN; m_tvalid and s_tready rise on the edge
//   that ends FIN. s_tready is high only while the sequencer is idle.
// Stall:
//   A result waits in the output register while m_tready is low; the next
//   request is still taken and runs up to its final step, which holds until
//   the output register is free.
// Reset:
//   Gains and speed clear to zero, the previous error loads pi (Q2.13), the
//   integral clears, and no result is pending.
`include "heading_pid_controller_core_assert.svh"

module heading_pid_controller_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // goal_x [23:0], goal_y [47:24], robot_x [71:48], robot_y [95:72]
    input  logic [hpc_pkg::S_DATA_W-1:0]        s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // angular_rate [15:0], linear_rate [31:16], bearing_error [47:32]
    output logic [hpc_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CORDIC = 4'd1;
    localparam logic [3:0] ST_ROUND  = 4'd2;
    localparam logic [3:0] ST_DIVM   = 4'd3;
    localparam logic [3:0] ST_DIVF   = 4'd4;
    localparam logic [3:0] ST_INTEG  = 4'd5;
    localparam logic [3:0] ST_MULI   = 4'd6;
    localparam logic [3:0] ST_MULD   = 4'd7;
    localparam logic [3:0] ST_ACCD   = 4'd8;
    localparam logic [3:0] ST_FIN    = 4'd9;

    localparam int CW  = hpc_pkg::CORDIC_W;
    localparam int IW  = hpc_pkg::ITER_W;
    localparam int EW  = hpc_pkg::E_W;
    localparam int GW  = hpc_pkg::GAIN_W;
    localparam int AW  = hpc_pkg::ACC_W;
    localparam int MW  = hpc_pkg::MAG_W;

    logic [3:0]                          state_reg, state_next;
    logic [IW-1:0]                       iter_reg, iter_next;
    logic signed [CW-1:0]                x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic                                zero_reg, zero_next;
    logic signed [EW-1:0]                e_reg, e_next;
    logic signed [EW-1:0]                last_error_reg, last_error_next;
    logic signed [hpc_pkg::D_W-1:0]      d_reg, d_next;
    logic [MW-1:0]                       mag_reg, mag_next;
    logic                                neg_reg, neg_next;
    logic signed [hpc_pkg::INC_W-1:0]    inc_reg, inc_next;
    logic signed [hpc_pkg::INTEG_W-1:0]  integ_reg, integ_next;
    logic signed [hpc_pkg::INTEG_W-1:0]  running_integral_reg, running_integral_next;
    logic signed [hpc_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic signed [AW-1:0]                acc_reg, acc_next;
    logic signed [GW-1:0]                kp_reg, kp_next, ki_reg, ki_next;
    logic signed [GW-1:0]                kd_reg, kd_next, speed_reg, speed_next;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [hpc_pkg::M_DATA_W-1:0]        m_tdata_reg, m_tdata_next;

    logic signed [hpc_pkg::IN_W-1:0]     in_goal_x, in_goal_y, in_robot_x, in_robot_y;
    logic signed [hpc_pkg::DX_W-1:0]     dx, dy;
    logic signed [CW-1:0]                dx_ext, dy_ext, xs, ys, atan_term;
    logic signed [hpc_pkg::ZR_W-1:0]     z_rnd, z_sh;
    logic signed [EW-1:0]                bearing;
    logic signed [hpc_pkg::DIFF_W-1:0]   diff;
    logic signed [hpc_pkg::D_W-1:0]      diff_ext, rate_s;
    logic [hpc_pkg::EABS_W-1:0]          e_abs;
    logic [MW-1:0]                       q0, q0_times_rate, rem, quot;
    logic signed [hpc_pkg::INC_W-1:0]    quot_s;
    logic signed [hpc_pkg::INTEG_W:0]    integ_sum;
    logic signed [hpc_pkg::MUL_A_W-1:0]  mul_a;
    logic signed [hpc_pkg::MUL_B_W-1:0]  mul_b;
    logic signed [AW-1:0]                acc_rnd, acc_sh;
    logic signed [hpc_pkg::OUT_W-1:0]    ang;
    logic                                out_free, s_accept, y_pos;

    assign in_goal_x  = s_tdata[23:0];
    assign in_goal_y  = s_tdata[47:24];
    assign in_robot_x = s_tdata[71:48];
    assign in_robot_y = s_tdata[95:72];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        dx     = hpc_pkg::DX_W'(in_goal_x) - hpc_pkg::DX_W'(in_robot_x);
        dy     = hpc_pkg::DX_W'(in_goal_y) - hpc_pkg::DX_W'(in_robot_y);
        dx_ext = CW'(dx);
        dy_ext = CW'(dy);

        xs        = x_reg >>> iter_reg;
        ys        = y_reg >>> iter_reg;
        atan_term = hpc_pkg::atan_q24(hpc_pkg::ATAN_IDX_W'(iter_reg));
        y_pos     = !y_reg[CW-1] && (y_reg != '0);

        z_rnd = hpc_pkg::ZR_W'(z_reg) + hpc_pkg::ZR_W'(hpc_pkg::BEARING_HALF);
        z_sh  = z_rnd >>> hpc_pkg::BEARING_SH;
        if (zero_reg) begin
            bearing = '0;
        end else if (z_sh > hpc_pkg::ZR_W'(hpc_pkg::PI_Q13)) begin
            bearing = EW'(hpc_pkg::PI_Q13);
        end else if (z_sh < hpc_pkg::ZR_W'(-hpc_pkg::PI_Q13)) begin
            bearing = EW'(-hpc_pkg::PI_Q13);
        end else begin
            bearing = EW'(z_sh);
        end

        diff     = hpc_pkg::DIFF_W'(bearing) - hpc_pkg::DIFF_W'(last_error_reg);
        diff_ext = hpc_pkg::D_W'(diff);
        rate_s   = hpc_pkg::D_W'(hpc_pkg::UPDATE_RATE_HZ);
        e_abs    = bearing[EW-1] ? hpc_pkg::EABS_W'(-bearing) : hpc_pkg::EABS_W'(bearing);

        q0            = prod_reg[hpc_pkg::DIV_SH +: MW];
        q0_times_rate = MW'(q0 * MW'(hpc_pkg::UPDATE_RATE_HZ));
        rem           = mag_reg - q0_times_rate;
        quot          = (rem >= MW'(hpc_pkg::UPDATE_RATE_HZ)) ? q0 + MW'(1) : q0;
        quot_s        = $signed({1'b0, quot});

        integ_sum = (hpc_pkg::INTEG_W + 1)'(running_integral_reg)
                  + (hpc_pkg::INTEG_W + 1)'(inc_reg);

        acc_rnd = acc_reg + AW'(hpc_pkg::OUT_HALF);
        acc_sh  = acc_rnd >>> hpc_pkg::OUT_SH;
        if (acc_sh > AW'(hpc_pkg::OUT_MAX)) begin
            ang = hpc_pkg::OUT_W'(hpc_pkg::OUT_MAX);
        end else if (acc_sh < AW'(hpc_pkg::OUT_MIN)) begin
            ang = hpc_pkg::OUT_W'(hpc_pkg::OUT_MIN);
        end else begin
            ang = hpc_pkg::OUT_W'(acc_sh);
        end

        case (state_reg)
            ST_DIVM: begin
                mul_a = hpc_pkg::MUL_A_W'(hpc_pkg::RECIP);
                mul_b = $signed({{(hpc_pkg::MUL_B_W - MW){1'b0}}, mag_reg});
            end
            ST_INTEG: begin
                mul_a = hpc_pkg::MUL_A_W'(kp_reg);
                mul_b = hpc_pkg::MUL_B_W'(e_reg);
            end
            ST_MULI: begin
                mul_a = hpc_pkg::MUL_A_W'(ki_reg);
                mul_b = hpc_pkg::MUL_B_W'(integ_reg);
            end
            ST_MULD: begin
                mul_a = hpc_pkg::MUL_A_W'(kd_reg);
                mul_b = hpc_pkg::MUL_B_W'(d_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = hpc_pkg::PROD_W'(mul_a) * hpc_pkg::PROD_W'(mul_b);
    end

    always_comb begin
        state_next            = state_reg;
        iter_next             = iter_reg;
        x_next                = x_reg;
        y_next                = y_reg;
        z_next                = z_reg;
        zero_next             = zero_reg;
        e_next                = e_reg;
        last_error_next       = last_error_reg;
        d_next                = d_reg;
        mag_next              = mag_reg;
        neg_next              = neg_reg;
        inc_next              = inc_reg;
        integ_next            = integ_reg;
        running_integral_next = running_integral_reg;
        acc_next              = acc_reg;
        kp_next               = kp_reg;
        ki_next               = ki_reg;
        kd_next               = kd_reg;
        speed_next            = speed_reg;
        m_tvalid_next         = m_tvalid_reg;
        m_tdata_next          = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                hpc_pkg::REG_KP:    kp_next    = cfg_data;
                hpc_pkg::REG_KI:    ki_next    = cfg_data;
                hpc_pkg::REG_KD:    kd_next    = cfg_data;
                hpc_pkg::REG_SPEED: speed_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    zero_next = (dx == '0) && (dy == '0);
                    iter_next = '0;
                    if (dx[hpc_pkg::DX_W-1] && !dy[hpc_pkg::DX_W-1]) begin
                        x_next = dy_ext;
                        y_next = -dx_ext;
                        z_next = CW'(hpc_pkg::HALF_PI_Q24);
                    end else if (dx[hpc_pkg::DX_W-1]) begin
                        x_next = -dy_ext;
                        y_next = dx_ext;
                        z_next = CW'(-hpc_pkg::HALF_PI_Q24);
                    end else begin
                        x_next = dx_ext;
                        y_next = dy_ext;
                        z_next = '0;
                    end
                    state_next = ST_CORDIC;
                end
            end
            ST_CORDIC: begin
                if (y_pos) begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atan_term;
                end else begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atan_term;
                end
                if (iter_reg == IW'(hpc_pkg::CORDIC_ITERS - 1)) begin
                    iter_next  = '0;
                    state_next = ST_ROUND;
                end else begin
                    iter_next = iter_reg + IW'(1);
                end
            end
            ST_ROUND: begin
                e_next     = bearing;
                d_next     = diff_ext * rate_s;
                mag_next   = MW'({e_abs, {hpc_pkg::INT_SH{1'b0}}}) + MW'(hpc_pkg::HALF_RATE);
                neg_next   = bearing[EW-1];
                state_next = ST_DIVM;
            end
            ST_DIVM: begin
                state_next = ST_DIVF;
            end
            ST_DIVF: begin
                inc_next   = neg_reg ? -quot_s : quot_s;
                state_next = ST_INTEG;
            end
            ST_INTEG: begin
                if (integ_sum[hpc_pkg::INTEG_W] != integ_sum[hpc_pkg::INTEG_W-1]) begin
                    integ_next = integ_sum[hpc_pkg::INTEG_W]
                               ? {1'b1, {(hpc_pkg::INTEG_W - 1){1'b0}}}
                               : {1'b0, {(hpc_pkg::INTEG_W - 1){1'b1}}};
                end else begin
                    integ_next = integ_sum[hpc_pkg::INTEG_W-1:0];
                end
                state_next = ST_MULI;
            end
            ST_MULI: begin
                acc_next   = {prod_reg[AW-hpc_pkg::INT_SH-1:0], {hpc_pkg::INT_SH{1'b0}}};
                state_next = ST_MULD;
            end
            ST_MULD: begin
                acc_next   = acc_reg + prod_reg[AW-1:0];
                state_next = ST_ACCD;
            end
            ST_ACCD: begin
                acc_next   = acc_reg
                           + {prod_reg[AW-hpc_pkg::INT_SH-1:0], {hpc_pkg::INT_SH{1'b0}}};
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    m_tvalid_next         = 1'b1;
                    m_tdata_next          = {e_reg, speed_reg, ang};
                    last_error_next       = e_reg;
                    running_integral_next = integ_reg;
                    state_next            = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg            <= ST_IDLE;
            iter_reg             <= '0;
            last_error_reg       <= EW'(hpc_pkg::PI_Q13);
            running_integral_reg <= '0;
            kp_reg               <= '0;
            ki_reg               <= '0;
            kd_reg               <= '0;
            speed_reg            <= '0;
            m_tvalid_reg         <= 1'b0;
        end else begin
            state_reg            <= state_next;
            iter_reg             <= iter_next;
            last_error_reg       <= last_error_next;
            running_integral_reg <= running_integral_next;
            kp_reg               <= kp_next;
            ki_reg               <= ki_next;
            kd_reg               <= kd_next;
            speed_reg            <= speed_next;
            m_tvalid_reg         <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        zero_reg    <= zero_next;
        e_reg       <= e_next;
        d_reg       <= d_next;
        mag_reg     <= mag_next;
        neg_reg     <= neg_next;
        inc_reg     <= inc_next;
        integ_reg   <= integ_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        m_tdata_reg <= m_tdata_next;
    end

    `HPC_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `HPC_ASSERT_SAME(a_iter_idle, aclk, aresetn, state_reg != ST_CORDIC, iter_reg == '0)
    `HPC_ASSERT_NEXT(a_fin_holds, aclk, aresetn,
        (state_reg == ST_FIN) && m_tvalid_reg && !m_tready, state_reg == ST_FIN)
    `HPC_ASSERT_SAME(a_bearing_range, aclk, aresetn, m_tvalid,
        ($signed(m_tdata[47:32]) <= 16'sd25736) && ($signed(m_tdata[47:32]) >= -16'sd25736))

endmodule
